// File: rtl/lafo_pkg.sv
// Look-at frame package: pipeline depths, sideband types and helper functions.
// Used by the square root, divider and top-level files; depends on nothing.
package lafo_pkg;

    localparam int unsigned SQ_STG  = 32;   // one root bit pair per stage
    localparam int unsigned DIV_STG = 15;   // one quotient bit per stage
    localparam int unsigned LAT     = 4 + SQ_STG + DIV_STG + 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAME  = 2'd1;
    localparam logic [1:0] ST_VERT  = 2'd2;

    localparam logic [29:0] Q14_HALF = 30'd8192;

    typedef struct packed {
        logic [2:0]  neg;
        logic        coin;
        logic        vert;
        logic [29:0] n3x;
        logic [29:0] n3y;
        logic [29:0] n3z;
        logic [29:0] n2x;
        logic [29:0] n2y;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       coin;
        logic       vert;
    } t_flag;

    // Position of the highest set bit (0 when the word is zero).
    function automatic logic [4:0] f_msb(input logic [31:0] m);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) p = 5'(i);
        end
        return p;
    endfunction

    // Shift a magnitude so that bit p lands on bit 29; right shifts truncate.
    function automatic logic [29:0] f_norm(input logic [31:0] m, input logic [4:0] p);
        logic [31:0] s;
        if (p >= 5'd29) s = m >> (p - 5'd29);
        else            s = m << (5'd29 - p);
        return s[29:0];
    endfunction

    function automatic logic signed [15:0] f_enc(input logic [15:0] mag, input logic neg);
        return neg ? 16'(-mag) : mag;
    endfunction

endpackage

// File: rtl/lafo_sqrt.sv
// Pipelined integer square root, floor(sqrt(x)) of a 62-bit radicand.
// One bit pair per stage, SQ_STG stages; depends on lafo_pkg.
module lafo_sqrt import lafo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [61:0] i_rad,
    output logic [30:0] o_root
);

    logic [63:0] r_v   [SQ_STG];
    logic [63:0] r_res [SQ_STG];

    for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
        logic [63:0] v_in, res_in, bitv, trial;
        assign v_in   = (k == 0) ? 64'(i_rad) : r_v[(k == 0) ? 0 : k - 1];
        assign res_in = (k == 0) ? '0 : r_res[(k == 0) ? 0 : k - 1];
        assign bitv   = 64'(1) << (2 * (SQ_STG - 1 - k));
        assign trial  = res_in + bitv;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (v_in >= trial) begin
                    r_v[k]   <= v_in - trial;
                    r_res[k] <= (res_in >> 1) + bitv;
                end else begin
                    r_v[k]   <= v_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQ_STG-1][30:0];

endmodule

// File: rtl/lafo_div.sv
// Pipelined restoring divider giving a 15-bit quotient, one bit per stage.
// Numerator must stay below den * 2^15; depends on lafo_pkg.
module lafo_div import lafo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [45:0] i_num,
    input  logic [30:0] i_den,
    output logic [14:0] o_quo
);

    logic [45:0] r_rem [DIV_STG];
    logic [30:0] r_den [DIV_STG];
    logic [14:0] r_q   [DIV_STG];

    for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
        logic [45:0] rem_in, dsh;
        logic [30:0] den_in;
        logic [14:0] q_in;
        assign rem_in = (j == 0) ? i_num : r_rem[(j == 0) ? 0 : j - 1];
        assign den_in = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
        assign q_in   = (j == 0) ? '0    : r_q[(j == 0) ? 0 : j - 1];
        assign dsh    = 46'(den_in) << (DIV_STG - 1 - j);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_den[j] <= den_in;
                if (rem_in >= dsh) begin
                    r_rem[j] <= rem_in - dsh;
                    r_q[j]   <= q_in | (15'(1) << (DIV_STG - 1 - j));
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= q_in;
                end
            end
        end
    end

    assign o_quo = r_q[DIV_STG-1];

endmodule

// File: rtl/look_at_orientation_frame_unit.sv
// Look-at orientation frame: top level with the front stages and output stage.
// Depends on lafo_pkg, lafo_sqrt and lafo_div.
//
// Takes self and target positions (Q16.16) and returns side, up and back
// vectors (Q2.14) plus a status. One item enters per cycle while the output
// is not stalled; each item passes through 4 front stages (difference,
// block normalize, squares, sums), 32 square-root stages, 15 divider stages,
// and a product and an output stage. The whole pipeline holds while a result
// waits at the output, so o_in_ready is low only when the output is stalled.
module look_at_orientation_frame_unit import lafo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_self_x,
    input  logic signed [31:0] i_self_y,
    input  logic signed [31:0] i_self_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_side_x,
    output logic signed [15:0] o_side_y,
    output logic signed [15:0] o_side_z,
    output logic signed [15:0] o_up_x,
    output logic signed [15:0] o_up_y,
    output logic signed [15:0] o_up_z,
    output logic signed [15:0] o_back_x,
    output logic signed [15:0] o_back_y,
    output logic signed [15:0] o_back_z,
    output logic [1:0]         o_frame_status
);

    logic           ce;
    logic [LAT-1:0] r_vld;

    assign ce          = ~o_out_valid | i_out_ready;
    assign o_in_ready  = ce;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Stage 1: exact differences as sign and magnitude
    logic [32:0] dx, dy, dz;
    logic [31:0] r1_mx, r1_my, r1_mz;
    logic [2:0]  r1_neg;

    assign dx = {i_target_x[31], i_target_x} - {i_self_x[31], i_self_x};
    assign dy = {i_target_y[31], i_target_y} - {i_self_y[31], i_self_y};
    assign dz = {i_target_z[31], i_target_z} - {i_self_z[31], i_self_z};

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_neg <= {dz[32], dy[32], dx[32]};
            r1_mx  <= dx[32] ? 32'(-dx) : dx[31:0];
            r1_my  <= dy[32] ? 32'(-dy) : dy[31:0];
            r1_mz  <= dz[32] ? 32'(-dz) : dz[31:0];
        end
    end

    // Stage 2: block normalize; the OR of the magnitudes has the max's top bit
    logic [31:0] or3, or2;
    logic [4:0]  p3, p2;
    t_side       r2_sb, r3_sb, r4_sb;

    assign or3 = r1_mx | r1_my | r1_mz;
    assign or2 = r1_mx | r1_my;
    assign p3  = f_msb(or3);
    assign p2  = f_msb(or2);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_sb.neg  <= r1_neg;
            r2_sb.coin <= (or3 == '0);
            r2_sb.vert <= (or2 == '0);
            r2_sb.n3x  <= f_norm(r1_mx, p3);
            r2_sb.n3y  <= f_norm(r1_my, p3);
            r2_sb.n3z  <= f_norm(r1_mz, p3);
            r2_sb.n2x  <= f_norm(r1_mx, p2);
            r2_sb.n2y  <= f_norm(r1_my, p2);
        end
    end

    // Stage 3: squares
    logic [59:0] sq_x, sq_y, sq_z, sq_hx, sq_hy;
    logic [59:0] r3_x, r3_y, r3_z, r3_hx, r3_hy;

    assign sq_x  = r2_sb.n3x * r2_sb.n3x;
    assign sq_y  = r2_sb.n3y * r2_sb.n3y;
    assign sq_z  = r2_sb.n3z * r2_sb.n3z;
    assign sq_hx = r2_sb.n2x * r2_sb.n2x;
    assign sq_hy = r2_sb.n2y * r2_sb.n2y;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_sb <= r2_sb;
            r3_x  <= sq_x;
            r3_y  <= sq_y;
            r3_z  <= sq_z;
            r3_hx <= sq_hx;
            r3_hy <= sq_hy;
        end
    end

    // Stage 4: sums of squares
    logic [61:0] r4_s3, r4_s2, r4_sh;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_sb <= r3_sb;
            r4_s3 <= 62'(r3_x) + 62'(r3_y) + 62'(r3_z);
            r4_s2 <= 62'(r3_hx) + 62'(r3_hy);
            r4_sh <= 62'(r3_x) + 62'(r3_y);
        end
    end

    // Square roots, with the sideband delayed alongside
    logic [30:0] len, hlen, h3;
    t_side       r_sbd [SQ_STG];
    t_side       sb_q;

    lafo_sqrt u_sq_len  (.i_clk, .i_ce(ce), .i_rad(r4_s3), .o_root(len));
    lafo_sqrt u_sq_hlen (.i_clk, .i_ce(ce), .i_rad(r4_s2), .o_root(hlen));
    lafo_sqrt u_sq_h3   (.i_clk, .i_ce(ce), .i_rad(r4_sh), .o_root(h3));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sbd[0] <= r4_sb;
            for (int k = 1; k < SQ_STG; k++) r_sbd[k] <= r_sbd[k-1];
        end
    end

    assign sb_q = r_sbd[SQ_STG-1];

    // Divisions: floor((mag * 2^14 + floor(L/2)) / L)
    logic [45:0] len_half, hlen_half;
    logic [14:0] q_bx, q_by, q_bz, q_sx, q_sy, q_uz;
    t_flag       r_fld [DIV_STG];

    assign len_half  = 46'(len >> 1);
    assign hlen_half = 46'(hlen >> 1);

    lafo_div u_div_bx (.i_clk, .i_ce(ce), .i_num((46'(sb_q.n3x) << 14) + len_half),
                       .i_den(len), .o_quo(q_bx));
    lafo_div u_div_by (.i_clk, .i_ce(ce), .i_num((46'(sb_q.n3y) << 14) + len_half),
                       .i_den(len), .o_quo(q_by));
    lafo_div u_div_bz (.i_clk, .i_ce(ce), .i_num((46'(sb_q.n3z) << 14) + len_half),
                       .i_den(len), .o_quo(q_bz));
    lafo_div u_div_sx (.i_clk, .i_ce(ce), .i_num((46'(sb_q.n2y) << 14) + hlen_half),
                       .i_den(hlen), .o_quo(q_sx));
    lafo_div u_div_sy (.i_clk, .i_ce(ce), .i_num((46'(sb_q.n2x) << 14) + hlen_half),
                       .i_den(hlen), .o_quo(q_sy));
    lafo_div u_div_uz (.i_clk, .i_ce(ce), .i_num((46'(h3) << 14) + len_half),
                       .i_den(len), .o_quo(q_uz));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fld[0] <= '{neg: sb_q.neg, coin: sb_q.coin, vert: sb_q.vert};
            for (int j = 1; j < DIV_STG; j++) r_fld[j] <= r_fld[j-1];
        end
    end

    // Product stage for the up vector's x and y
    t_flag       r_mf;
    logic [14:0] r_bx, r_by, r_bz, r_sx, r_sy, r_uz;
    logic [29:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mf <= r_fld[DIV_STG-1];
            r_bx <= q_bx;
            r_by <= q_by;
            r_bz <= q_bz;
            r_sx <= q_sx;
            r_sy <= q_sy;
            r_uz <= q_uz;
            r_py <= 30'(q_sy) * 30'(q_bz);
            r_px <= 30'(q_sx) * 30'(q_bz);
        end
    end

    // Output stage: round, apply signs, mask special cases
    logic [30:0] rnd_x, rnd_y;
    logic        sxneg, syneg, fzneg, no_frame;

    assign rnd_x    = 31'(r_py) + 31'(Q14_HALF);
    assign rnd_y    = 31'(r_px) + 31'(Q14_HALF);
    assign sxneg    = r_mf.neg[1];
    assign syneg    = ~r_mf.neg[0];
    assign fzneg    = r_mf.neg[2];
    assign no_frame = r_mf.coin | r_mf.vert;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_side_z <= '0;
            if (r_mf.coin) begin
                o_frame_status <= ST_SAME;
                o_back_x <= '0;
                o_back_y <= '0;
                o_back_z <= '0;
            end else begin
                o_frame_status <= r_mf.vert ? ST_VERT : ST_OK;
                o_back_x <= f_enc(16'(r_bx), ~r_mf.neg[0]);
                o_back_y <= f_enc(16'(r_by), ~r_mf.neg[1]);
                o_back_z <= f_enc(16'(r_bz), ~r_mf.neg[2]);
            end
            if (no_frame) begin
                o_side_x <= '0;
                o_side_y <= '0;
                o_up_x   <= '0;
                o_up_y   <= '0;
                o_up_z   <= '0;
            end else begin
                o_side_x <= f_enc(16'(r_sx), sxneg);
                o_side_y <= f_enc(16'(r_sy), syneg);
                o_up_x   <= f_enc(rnd_x[29:14], syneg ^ fzneg);
                o_up_y   <= f_enc(rnd_y[29:14], ~(sxneg ^ fzneg));
                o_up_z   <= 16'(r_uz);
            end
        end
    end

endmodule

// File: sim/look_at_orientation_frame_checker.sv
// Checker for the look-at frame unit: watches both channels, predicts each frame
// and compares it field by field. Depends on lafo_pkg for the status codes.
module look_at_orientation_frame_checker import lafo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_self_x,
    input  logic signed [31:0] i_self_y,
    input  logic signed [31:0] i_self_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [9:0][15:0]   i_frame,      // side xyz, up xyz, back xyz, status
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [9:0][15:0] frame_q[$];
    int err_count = 0;

    assign o_pending = frame_q.size();
    assign o_errors  = err_count;

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Shift all magnitudes together until the largest lies in [2^29, 2^30).
    function automatic logic [2:0][63:0] align_mags(input logic [2:0][63:0] m);
        logic [63:0] mx;
        mx = 0;
        for (int i = 0; i < 3; i++) if (m[i] > mx) mx = m[i];
        if (mx == 0) return m;
        while (mx >= 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < 64'h2000_0000) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        return m;
    endfunction

    function automatic logic [63:0] to_q14(input logic [63:0] mag, input logic [63:0] len);
        if (len == 0) return 0;
        return (mag * 64'd16384 + (len >> 1)) / len;
    endfunction

    function automatic logic [15:0] signed_q14(input logic [63:0] mag, input logic neg);
        logic [15:0] m;
        m = mag[15:0];
        if (m == 0) return 16'd0;
        return neg ? 16'(-m) : m;
    endfunction

    function automatic logic [9:0][15:0] look_at_frame(input logic signed [31:0] s[3],
                                                       input logic signed [31:0] t[3]);
        logic [9:0][15:0] fr;
        logic [2:0][63:0] m3, m2;
        logic [2:0] neg;
        longint dl;
        logic [63:0] len, hlen, h3, fzm, sxm, sym;
        fr = '0;
        m2 = '0;
        for (int i = 0; i < 3; i++) begin
            dl = longint'(t[i]) - longint'(s[i]);
            neg[i] = dl < 0;
            m3[i] = neg[i] ? 64'(-dl) : 64'(dl);
        end
        if (m3 == '0) begin
            fr[9] = 16'(ST_SAME);
            return fr;
        end
        m2[0] = m3[0];
        m2[1] = m3[1];
        m3 = align_mags(m3);
        len = root_floor(m3[0] * m3[0] + m3[1] * m3[1] + m3[2] * m3[2]);
        for (int i = 0; i < 3; i++) fr[6 + i] = signed_q14(to_q14(m3[i], len), !neg[i]);
        if (m2 == '0) begin
            fr[9] = 16'(ST_VERT);
            return fr;
        end
        fzm = to_q14(m3[2], len);
        m2 = align_mags(m2);
        hlen = root_floor(m2[0] * m2[0] + m2[1] * m2[1]);
        sxm = to_q14(m2[1], hlen);
        sym = to_q14(m2[0], hlen);
        fr[0] = signed_q14(sxm, neg[1]);
        fr[1] = signed_q14(sym, !neg[0]);
        fr[3] = signed_q14((sym * fzm + 64'd8192) >> 14, (!neg[0]) != neg[2]);
        fr[4] = signed_q14((sxm * fzm + 64'd8192) >> 14, !(neg[1] != neg[2]));
        h3 = root_floor(m3[0] * m3[0] + m3[1] * m3[1]);
        fr[5] = signed_q14(to_q14(h3, len), 1'b0);
        fr[9] = 16'(ST_OK);
        return fr;
    endfunction

    always @(posedge i_clk) begin
        logic [9:0][15:0] want;
        int bad;
        bad = 0;
        if (i_rst_n && i_in_valid && i_in_ready)
            frame_q.insert(frame_q.size(),
                           look_at_frame('{i_self_x, i_self_y, i_self_z},
                                         '{i_target_x, i_target_y, i_target_z}));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                $display("%t: frame with none expected, got %h", $time, i_frame);
                bad++;
            end else begin
                want = frame_q.pop_front();
                for (int i = 0; i < 10; i++) begin
                    if (want[i] != i_frame[i]) begin
                        $display("%t: field %0d expected %h, got %h",
                                 $time, i, want[i], i_frame[i]);
                        bad++;
                    end
                end
            end
        end
        err_count <= err_count + bad;
    end
endmodule

// File: sim/testbench.sv
// Top of the look-at frame testbench: clock, reset, stimulus and verdict.
// Depends on lafo_pkg, the RTL top level and look_at_orientation_frame_checker.
module testbench import lafo_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos[6] = '{default: '0};   // self xyz, target xyz
    logic signed [15:0] side_x, side_y, side_z, up_x, up_y, up_z, back_x, back_y, back_z;
    logic [1:0] frame_status;
    int errors, pending;
    int burst_left = 0;
    bit hold_go = 1'b0;

    always #5 i_clk = ~i_clk;

    look_at_orientation_frame_unit dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_self_x(pos[0]), .i_self_y(pos[1]), .i_self_z(pos[2]),
        .i_target_x(pos[3]), .i_target_y(pos[4]), .i_target_z(pos[5]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_side_x(side_x), .o_side_y(side_y), .o_side_z(side_z),
        .o_up_x(up_x), .o_up_y(up_y), .o_up_z(up_z),
        .o_back_x(back_x), .o_back_y(back_y), .o_back_z(back_z),
        .o_frame_status(frame_status)
    );

    look_at_orientation_frame_checker frame_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_self_x(pos[0]), .i_self_y(pos[1]), .i_self_z(pos[2]),
        .i_target_x(pos[3]), .i_target_y(pos[4]), .i_target_z(pos[5]),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_frame({14'd0, frame_status, back_z, back_y, back_x,
                  up_z, up_y, up_x, side_z, side_y, side_x}),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: stall pattern changes at random; a hold request blocks it for long.
    initial begin
        int mode, hold;
        bit held;
        mode = 0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !held) begin
                held = 1'b1;
                hold = 300;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // Offer one item at the falling edge, hold it until accepted; gaps fall between bursts.
    task automatic send_pair(input logic signed [31:0] s[3], input logic signed [31:0] t[3]);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pos <= '{s[0], s[1], s[2], t[0], t[1], t[2]};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic signed [31:0] s[3], t[3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            s[i] = $urandom;
            t[i] = kind == 0 ? $urandom : s[i] + ($signed($urandom) >>> $urandom_range(0, 31));
        end
        case (kind)
            1: t = s;                                           // coincide
            2: begin t[0] = s[0]; t[1] = s[1]; end              // vertical
            3: begin t[1] = s[1]; t[2] = s[2]; end              // along x
            4: t[2] = s[2];                                     // level
            default: ;
        endcase
        send_pair(s, t);
    endtask

    initial begin
        logic signed [31:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pair('{0, 0, 0}, '{0, 0, 0});
        send_pair('{mx, mn, 5}, '{mx, mn, 5});
        send_pair('{0, 0, 0}, '{0, 0, 1});
        send_pair('{0, 0, 0}, '{0, 0, -1});
        send_pair('{0, 0, mn}, '{0, 0, mx});
        send_pair('{0, 0, mx}, '{0, 0, mn});
        send_pair('{mn, mn, mn}, '{mx, mx, mx});
        send_pair('{mx, mx, mx}, '{mn, mn, mn});
        send_pair('{mn, mx, mn}, '{mx, mn, mx});
        send_pair('{0, 0, 0}, '{1, 0, 0});
        send_pair('{0, 0, 0}, '{0, -1, 0});
        send_pair('{0, 0, 0}, '{1, 1, 1});
        send_pair('{0, 0, 0}, '{-1, 1, -1});
        send_pair('{mn, 0, 0}, '{mx, 0, 0});
        send_pair('{0, mx, 0}, '{0, mn, 0});
        send_pair('{0, 0, 0}, '{1, 0, mx});
        send_pair('{0, 0, 0}, '{mx, 1, 0});
        send_pair('{65536, 0, 0}, '{0, 65536, 65536});
        send_pair('{0, 0, 0}, '{3, -4, 12});
        for (int n = 0; n < 1800; n++) begin
            if (n == 400) hold_go = 1'b1;
            if (n == 1000) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            send_random();
        end
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
rtl/lafo_pkg.sv
rtl/lafo_sqrt.sv
rtl/lafo_div.sv
rtl/look_at_orientation_frame_unit.sv
sim/look_at_orientation_frame_checker.sv
sim/testbench.sv
